@@ hw/rtl/distinct_prime_factor_count_core_assert.svh @@
// Assertion macros shared by the distinct prime factor counter RTL.
`ifndef DISTINCT_PRIME_FACTOR_COUNT_CORE_ASSERT_SVH
`define DISTINCT_PRIME_FACTOR_COUNT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DPFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DPFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dpfc_pkg.sv @@
// Package with shared types and constants of the distinct prime factor counter.
package dpfc_pkg;

  localparam int unsigned COUNT_BITS = 4;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } seq_state_e;

endpackage

@@ hw/rtl/dpfc_div.sv @@
// Shared restoring divider that yields one quotient bit per cycle.
module dpfc_div #(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  `include "distinct_prime_factor_count_core_assert.svh"

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    part_q, part_d;
  logic [W-1:0]  quot_q, quot_d;
  logic [W-1:0]  dvsr_q, dvsr_d;

  logic [W:0]    part_shift;
  logic [W:0]    part_diff;
  logic          fits;

  assign part_shift = {part_q[W-1:0], quot_q[W-1]};
  assign fits       = part_shift >= {1'b0, dvsr_q};
  assign part_diff  = part_shift - {1'b0, dvsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    part_d = part_q;
    quot_d = quot_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      part_d = '0;
      quot_d = dividend_i;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      part_d = fits ? part_diff : part_shift;
      quot_d = {quot_q[W-2:0], fits};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    quot_q <= quot_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = part_q[W-1:0];

  `DPFC_ASSERT_NOW(a_no_start_while_busy, busy_q, !start_i, "divider restarted while busy")
  `DPFC_ASSERT_NOW(a_done_not_busy, done_q, !busy_q, "divider done while still busy")

endmodule

@@ hw/rtl/dpfc_seq.sv @@
// Sequencer that drives trial division on the shared divider and counts primes.
module dpfc_seq
  import dpfc_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] value_i,
  output logic         idle_o,
  output logic         res_valid_o,
  input  logic         res_take_i,
  output count_t       count_o
);

  `include "distinct_prime_factor_count_core_assert.svh"

  seq_state_e   state_q, state_d;
  logic         hit_q, hit_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] dvsr_q, dvsr_d;
  count_t       cnt_q, cnt_d;

  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_quot;
  logic [W-1:0] div_rem;

  logic         in_ok;
  logic         rem_zero;
  logic         dvsr_gt_quot;
  logic         rem_gt_one;

  // Only positive values above one have prime factors.
  assign in_ok        = !value_i[W-1] && (|value_i[W-2:1]);
  assign rem_zero     = div_rem == '0;
  assign dvsr_gt_quot = dvsr_q > div_quot;
  assign rem_gt_one   = |rem_q[W-1:1];

  dpfc_div #(
    .W(W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(rem_d),
    .divisor_i (dvsr_d),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = in_ok ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done && !hit_q && dvsr_gt_quot) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rem_d     = rem_q;
    dvsr_d    = dvsr_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          rem_d     = value_i;
          dvsr_d    = W'(2);
          cnt_d     = '0;
          hit_d     = 1'b0;
          div_start = in_ok;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (hit_q) begin
            // The divisor is already counted: keep dividing it out.
            if (rem_zero) begin
              rem_d = div_quot;
            end else begin
              dvsr_d = dvsr_q + W'(1);
              hit_d  = 1'b0;
            end
            div_start = 1'b1;
          end else if (dvsr_gt_quot) begin
            // Divisor squared exceeds the remainder, so any leftover is prime.
            cnt_d = cnt_q + count_t'(rem_gt_one);
          end else if (rem_zero) begin
            cnt_d     = cnt_q + count_t'(1);
            hit_d     = 1'b1;
            rem_d     = div_quot;
            div_start = 1'b1;
          end else begin
            dvsr_d    = dvsr_q + W'(1);
            div_start = 1'b1;
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    cnt_q  <= cnt_d;
  end

  assign idle_o      = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_DONE;
  assign count_o     = cnt_q;

  `DPFC_ASSERT_NOW(a_hit_only_in_div, hit_q, state_q == ST_DIV, "divide-out flag outside search")
  `DPFC_ASSERT_NOW(a_divisor_above_one, state_q == ST_DIV, dvsr_q > W'(1), "trial divisor below two")

endmodule

@@ hw/rtl/distinct_prime_factor_count_core.sv @@
// Top level of the distinct prime factor counter with handshakes and result register.
//
//   Channel  Signals                                   Dir  Carries
//   in       in_valid_i, in_stall_o, value_i           in   one signed integer per request
//   out      out_valid_o, out_stall_i, factor_count_o  out  count of distinct primes
//
// Each request is factored by trial division. Divisors rise from two; one shared
// restoring divider, one quotient bit per cycle, gives both the quotient and the
// remainder of every trial step. A request needs one step per trial divisor up to
// the square root, plus further steps to divide out each prime found; at 32 bits
// a large prime needs about 46,341 steps. Values at or below one skip the search:
// the sequencer goes straight to its done state, and the result then passes
// through the result register.
// Reset is asynchronous and active low; it returns the sequencer to idle and empties
// the result register. in_stall_o is high until the sequencer has handed over a
// request's result. A finished result waits in the sequencer while out_stall_i
// holds the result register full, and a new request is taken once it is handed over.
module distinct_prime_factor_count_core
  import dpfc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [COUNT_BITS-1:0]        factor_count_o
);

  `include "distinct_prime_factor_count_core_assert.svh"

  logic   seq_idle;
  logic   seq_res_valid;
  logic   seq_res_take;
  count_t seq_count;
  logic   in_accept;

  logic   out_valid_q, out_valid_d;
  count_t count_q, count_d;

  // A request enters only while the sequencer is idle.
  assign in_stall_o = !seq_idle;
  assign in_accept  = in_valid_i && !in_stall_o;

  // The result register takes a new count whenever it is empty or being drained.
  assign seq_res_take = seq_res_valid && (!out_valid_q || !out_stall_i);

  dpfc_seq #(
    .W(VALUE_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .value_i    (value_i),
    .idle_o     (seq_idle),
    .res_valid_o(seq_res_valid),
    .res_take_i (seq_res_take),
    .count_o    (seq_count)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    count_d     = count_q;
    if (seq_res_take) begin
      out_valid_d = 1'b1;
      count_d     = seq_count;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign factor_count_o = count_q;

  `DPFC_ASSERT_NEXT(a_accept_leaves_idle, in_accept, !seq_idle, "sequencer idle after a request")

endmodule
